FILE: rtl/etuc_pkg.sv
// etuc_pkg: constants, month table and result struct for the epoch to calendar converter
// used by epoch_seconds_to_utc_calendar; depends on nothing else
`timescale 1ns / 1ps

package etuc_pkg;

   localparam int SECONDS_WIDTH_DEFAULT = 34;
   localparam int PIPE_STAGES = 14;

   // 86400 = 675 << 7
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int DAY_SHIFT     = 7;
   localparam int DAY_ODD       = 675;
   localparam int DAY_ODD_W     = 10;
   localparam int SPLIT_BITS    = 12;
   localparam int TOD_W         = DAY_ODD_W + DAY_SHIFT;
   localparam int HOUR_REM_W    = 12;

   localparam int DAYS_PER_WEEK = 7;
   localparam int EPOCH_WEEKDAY = 4;

   // civil calendar counted from 0000-03-01
   localparam int MARCH_EPOCH_DAYS = 719468;
   localparam int DAYS_PER_400Y    = 146097;
   localparam int DAYS_PER_100Y    = 36524;
   localparam int DAYS_PER_4Y      = 1460;
   localparam int DAYS_PER_YEAR    = 365;
   localparam int YEARS_PER_ERA    = 400;
   localparam int YEARS_PER_CENT   = 100;
   localparam int DOE_W            = 18;
   localparam int YOE_W            = 9;

   localparam int YEAR_OFFSET   = 1900;
   localparam int JAN_FIRST_DAY = 306;
   localparam int JAN_FEB_DAYS  = 59;
   localparam int FIRST_JAN_MP  = 10;
   localparam int MONTHS        = 12;
   localparam int MARCH_INDEX   = 2;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
   } tod_type;

   // first day of each month in a year that starts on March 1
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] d;
      unique case (mp)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/epoch_seconds_to_utc_calendar.sv
// epoch_seconds_to_utc_calendar: fourteen stage pipeline from epoch seconds to UTC date and time
// depends on etuc_pkg for constants, the month table and tod_type
`timescale 1ns / 1ps

// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into second, minute,
// hour, weekday (0 is Sunday), year less 1900, day of year, month (0 is January) and day of
// month, with Gregorian leap years. The pipeline takes one transfer per cycle as long as the
// result side keeps up; across its 14 register stages each multiply by a constant reciprocal
// sits in a stage apart from the compare-and-subtract correction that follows it. Stages move
// independently, so an empty stage is filled even while a finished result waits on rsp_stall.
// No state is kept between items. Input bits at or above SECONDS_WIDTH do not exist; years
// beyond 1923 + 1000 wrap in years_since_1900.
module epoch_seconds_to_utc_calendar
   import etuc_pkg::*;
#(
   parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SECONDS_WIDTH-1:0] req_epoch_seconds,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [5:0]               rsp_second,
   output logic [5:0]               rsp_minute,
   output logic [4:0]               rsp_hour,
   output logic [2:0]               rsp_weekday,
   output logic [9:0]               rsp_years_since_1900,
   output logic [8:0]               rsp_day_of_year,
   output logic [3:0]               rsp_month_index,
   output logic [4:0]               rsp_day_of_month
);

   // day split: seconds >> 7 = nh * 2^SPLIT_BITS + nl, divided by 675 in two passes
   localparam int NH_W = SECONDS_WIDTH - DAY_SHIFT - SPLIT_BITS;
   localparam logic [63:0] R1 = (64'd1 << NH_W) / 64'(DAY_ODD);
   localparam int R1_W = $clog2(R1 + 64'd1);
   localparam int QH_W = NH_W - DAY_ODD_W + 1;
   localparam int M_W  = DAY_ODD_W + SPLIT_BITS;
   localparam logic [63:0] R2 = (64'd1 << M_W) / 64'(DAY_ODD);
   localparam int R2_W = $clog2(R2 + 64'd1);
   localparam int D_W  = QH_W + SPLIT_BITS;

   localparam logic [63:0] RH = (64'd1 << TOD_W) / 64'(SECS_PER_HOUR);
   localparam int RH_W = $clog2(RH + 64'd1);
   localparam logic [63:0] RM = (64'd1 << HOUR_REM_W) / 64'(SECS_PER_MIN);
   localparam int RM_W = $clog2(RM + 64'd1);

   localparam int ZBASE_W = $clog2(MARCH_EPOCH_DAYS + 1);
   localparam int ZW = ((D_W > ZBASE_W) ? D_W : ZBASE_W) + 1;
   localparam logic [63:0] RE = (64'd1 << ZW) / 64'(DAYS_PER_400Y);
   localparam int RE_W  = $clog2(RE + 64'd1);
   localparam int ERA_W = ZW - $clog2(DAYS_PER_400Y) + 1;
   localparam int Y_W   = ERA_W + YOE_W + 1;

   localparam int W7 = D_W + 1;
   localparam logic [63:0] R7 = (64'd1 << W7) / 64'(DAYS_PER_WEEK);
   localparam int R7_W = $clog2(R7 + 64'd1);

   localparam logic [63:0] R4Y = (64'd1 << DOE_W) / 64'(DAYS_PER_4Y);
   localparam int R4Y_W = $clog2(R4Y + 64'd1);
   localparam logic [63:0] RC = (64'd1 << DOE_W) / 64'(DAYS_PER_100Y);
   localparam int RC_W = $clog2(RC + 64'd1);
   localparam logic [63:0] RY = (64'd1 << DOE_W) / 64'(DAYS_PER_YEAR);
   localparam int RY_W = $clog2(RY + 64'd1);

   // pipeline control
   logic [PIPE_STAGES-1:0] vld_ff, vld_in, adv;

   // stage 0
   logic [NH_W-1:0]       s0_nh_ff, s0_nh_in;
   logic [SPLIT_BITS-1:0] s0_nl_ff, s0_nl_in;
   logic [DAY_SHIFT-1:0]  s0_lo_ff, s0_lo_in;
   logic [NH_W+R1_W-1:0]  s0_prod_ff, s0_prod_in;
   // stage 1
   logic [QH_W-1:0]       s1_qh_ff, s1_qh_in;
   logic [DAY_ODD_W-1:0]  s1_rh_ff, s1_rh_in;
   logic [SPLIT_BITS-1:0] s1_nl_ff, s1_nl_in;
   logic [DAY_SHIFT-1:0]  s1_lo_ff, s1_lo_in;
   logic [QH_W-1:0]       qh_est;
   logic [NH_W-1:0]       rh_full;
   // stage 2
   logic [QH_W-1:0]       s2_qh_ff, s2_qh_in;
   logic [DAY_SHIFT-1:0]  s2_lo_ff, s2_lo_in;
   logic [M_W-1:0]        s2_m_ff, s2_m_in;
   logic [M_W+R2_W-1:0]   s2_prod_ff, s2_prod_in;
   // stage 3
   logic [D_W-1:0]        s3_days_ff, s3_days_in;
   logic [TOD_W-1:0]      s3_rem_ff, s3_rem_in;
   logic [SPLIT_BITS-1:0] ql_est, ql;
   logic [M_W-1:0]        rl_full;
   logic [DAY_ODD_W-1:0]  rl;
   // stage 4
   logic [ZW-1:0]         s4_z_ff, s4_z_in;
   logic [ZW+RE_W-1:0]    s4_pe_ff, s4_pe_in;
   logic [W7-1:0]         s4_w_ff, s4_w_in;
   logic [W7+R7_W-1:0]    s4_p7_ff, s4_p7_in;
   logic [TOD_W-1:0]      s4_rem_ff, s4_rem_in;
   logic [TOD_W+RH_W-1:0] s4_ph_ff, s4_ph_in;
   // stage 5
   logic [ERA_W-1:0]      s5_era_ff, s5_era_in;
   logic [DOE_W-1:0]      s5_doe_ff, s5_doe_in;
   logic [2:0]            s5_wd_ff, s5_wd_in;
   logic [4:0]            s5_hour_ff, s5_hour_in;
   logic [HOUR_REM_W-1:0] s5_r2_ff, s5_r2_in;
   logic [ERA_W-1:0]      era_est;
   logic [ZW-1:0]         doe_full;
   logic [W7-3:0]         q7_est;
   logic [W7-1:0]         r7_full;
   logic [4:0]            hour_est;
   logic [TOD_W-1:0]      hr_full;
   // stage 6
   logic [ERA_W-1:0]       s6_era_ff, s6_era_in;
   logic [DOE_W-1:0]       s6_doe_ff, s6_doe_in;
   logic                   s6_c_ff, s6_c_in;
   logic [2:0]             s6_wd_ff, s6_wd_in;
   logic [4:0]             s6_hour_ff, s6_hour_in;
   logic [HOUR_REM_W-1:0]  s6_r2_ff, s6_r2_in;
   logic [DOE_W+R4Y_W-1:0] s6_p4y_ff, s6_p4y_in;
   logic [DOE_W+RC_W-1:0]  s6_pc_ff, s6_pc_in;
   logic [HOUR_REM_W+RM_W-1:0] s6_pm_ff, s6_pm_in;
   // stage 7
   logic [ERA_W-1:0]      s7_era_ff, s7_era_in;
   logic [DOE_W-1:0]      s7_doe_ff, s7_doe_in;
   logic                  s7_c_ff, s7_c_in;
   logic [6:0]            s7_a_ff, s7_a_in;
   logic [2:0]            s7_b_ff, s7_b_in;
   tod_type               s7_tod_ff, s7_tod_in;
   logic [6:0]            a_est;
   logic [DOE_W-1:0]      a_full;
   logic [2:0]            b_est;
   logic [DOE_W-1:0]      b_full;
   logic [5:0]            min_est;
   logic [HOUR_REM_W-1:0] mr_full;
   // stage 8
   logic [ERA_W-1:0]      s8_era_ff, s8_era_in;
   logic [DOE_W-1:0]      s8_doe_ff, s8_doe_in;
   logic [DOE_W-1:0]      s8_t_ff, s8_t_in;
   tod_type               s8_tod_ff, s8_tod_in;
   // stage 9
   logic [ERA_W-1:0]      s9_era_ff, s9_era_in;
   logic [DOE_W-1:0]      s9_doe_ff, s9_doe_in;
   logic [DOE_W-1:0]      s9_t_ff, s9_t_in;
   logic [DOE_W+RY_W-1:0] s9_py_ff, s9_py_in;
   tod_type               s9_tod_ff, s9_tod_in;
   // stage 10
   logic [ERA_W-1:0]      s10_era_ff, s10_era_in;
   logic [DOE_W-1:0]      s10_doe_ff, s10_doe_in;
   logic [YOE_W-1:0]      s10_yoe_ff, s10_yoe_in;
   tod_type               s10_tod_ff, s10_tod_in;
   logic [YOE_W-1:0]      yoe_est;
   logic [DOE_W-1:0]      yr_full;
   // stage 11
   logic [8:0]            s11_doy_ff, s11_doy_in;
   logic                  s11_leap_ff, s11_leap_in;
   logic [Y_W-1:0]        s11_year_ff, s11_year_in;
   tod_type               s11_tod_ff, s11_tod_in;
   logic [1:0]            cent;
   // stage 12
   logic [8:0]            s12_doy_ff, s12_doy_in;
   logic                  s12_leap_ff, s12_leap_in;
   logic [Y_W-1:0]        s12_year_ff, s12_year_in;
   logic [3:0]            s12_mp_ff, s12_mp_in;
   tod_type               s12_tod_ff, s12_tod_in;
   logic [MONTHS-2:0]     month_ge;
   // stage 13, the result register
   tod_type               s13_tod_ff, s13_tod_in;
   logic [9:0]            s13_year_ff, s13_year_in;
   logic [8:0]            s13_doy_ff, s13_doy_in;
   logic [3:0]            s13_month_ff, s13_month_in;
   logic [4:0]            s13_dom_ff, s13_dom_in;
   logic                  jan_feb;
   logic [Y_W-1:0]        year_full;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[PIPE_STAGES-1] = !vld_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[PIPE_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // days and seconds of the day
   always_comb begin
      s0_nh_in   = req_epoch_seconds[SECONDS_WIDTH-1 -: NH_W];
      s0_nl_in   = req_epoch_seconds[DAY_SHIFT +: SPLIT_BITS];
      s0_lo_in   = req_epoch_seconds[DAY_SHIFT-1:0];
      s0_prod_in = s0_nh_in * R1[R1_W-1:0];

      qh_est  = QH_W'(s0_prod_ff >> NH_W);
      rh_full = NH_W'(s0_nh_ff - qh_est * DAY_ODD);
      if (rh_full >= NH_W'(DAY_ODD)) begin
         s1_qh_in = qh_est + QH_W'(1);
         s1_rh_in = DAY_ODD_W'(rh_full - NH_W'(DAY_ODD));
      end else begin
         s1_qh_in = qh_est;
         s1_rh_in = DAY_ODD_W'(rh_full);
      end
      s1_nl_in = s0_nl_ff;
      s1_lo_in = s0_lo_ff;

      s2_m_in    = {s1_rh_ff, s1_nl_ff};
      s2_prod_in = s2_m_in * R2[R2_W-1:0];
      s2_qh_in   = s1_qh_ff;
      s2_lo_in   = s1_lo_ff;

      ql_est  = SPLIT_BITS'(s2_prod_ff >> M_W);
      rl_full = M_W'(s2_m_ff - ql_est * DAY_ODD);
      if (rl_full >= M_W'(DAY_ODD)) begin
         ql = ql_est + SPLIT_BITS'(1);
         rl = DAY_ODD_W'(rl_full - M_W'(DAY_ODD));
      end else begin
         ql = ql_est;
         rl = DAY_ODD_W'(rl_full);
      end
      s3_days_in = {s2_qh_ff, ql};
      s3_rem_in  = {rl, s2_lo_ff};
   end

   // era, weekday and hour
   always_comb begin
      s4_z_in   = ZW'(s3_days_ff) + ZW'(MARCH_EPOCH_DAYS);
      s4_pe_in  = s4_z_in * RE[RE_W-1:0];
      s4_w_in   = W7'(s3_days_ff) + W7'(EPOCH_WEEKDAY);
      s4_p7_in  = s4_w_in * R7[R7_W-1:0];
      s4_rem_in = s3_rem_ff;
      s4_ph_in  = s3_rem_ff * RH[RH_W-1:0];

      era_est  = ERA_W'(s4_pe_ff >> ZW);
      doe_full = ZW'(s4_z_ff - era_est * DAYS_PER_400Y);
      if (doe_full >= ZW'(DAYS_PER_400Y)) begin
         s5_era_in = era_est + ERA_W'(1);
         s5_doe_in = DOE_W'(doe_full - ZW'(DAYS_PER_400Y));
      end else begin
         s5_era_in = era_est;
         s5_doe_in = DOE_W'(doe_full);
      end

      q7_est  = (W7-2)'(s4_p7_ff >> W7);
      r7_full = W7'(s4_w_ff - q7_est * DAYS_PER_WEEK);
      if (r7_full >= W7'(DAYS_PER_WEEK)) begin
         s5_wd_in = 3'(r7_full - W7'(DAYS_PER_WEEK));
      end else begin
         s5_wd_in = 3'(r7_full);
      end

      hour_est = 5'(s4_ph_ff >> TOD_W);
      hr_full  = TOD_W'(s4_rem_ff - hour_est * SECS_PER_HOUR);
      if (hr_full >= TOD_W'(SECS_PER_HOUR)) begin
         s5_hour_in = hour_est + 5'd1;
         s5_r2_in   = HOUR_REM_W'(hr_full - TOD_W'(SECS_PER_HOUR));
      end else begin
         s5_hour_in = hour_est;
         s5_r2_in   = HOUR_REM_W'(hr_full);
      end
   end

   // century and four-year corrections, minute and second
   always_comb begin
      s6_era_in  = s5_era_ff;
      s6_doe_in  = s5_doe_ff;
      s6_c_in    = (s5_doe_ff == DOE_W'(DAYS_PER_400Y - 1));
      s6_wd_in   = s5_wd_ff;
      s6_hour_in = s5_hour_ff;
      s6_r2_in   = s5_r2_ff;
      s6_p4y_in  = s5_doe_ff * R4Y[R4Y_W-1:0];
      s6_pc_in   = s5_doe_ff * RC[RC_W-1:0];
      s6_pm_in   = s5_r2_ff * RM[RM_W-1:0];

      a_est  = 7'(s6_p4y_ff >> DOE_W);
      a_full = DOE_W'(s6_doe_ff - a_est * DAYS_PER_4Y);
      s7_a_in = (a_full >= DOE_W'(DAYS_PER_4Y)) ? a_est + 7'd1 : a_est;

      b_est  = 3'(s6_pc_ff >> DOE_W);
      b_full = DOE_W'(s6_doe_ff - b_est * DAYS_PER_100Y);
      s7_b_in = (b_full >= DOE_W'(DAYS_PER_100Y)) ? b_est + 3'd1 : b_est;

      min_est = 6'(s6_pm_ff >> HOUR_REM_W);
      mr_full = HOUR_REM_W'(s6_r2_ff - min_est * SECS_PER_MIN);
      if (mr_full >= HOUR_REM_W'(SECS_PER_MIN)) begin
         s7_tod_in.minute = min_est + 6'd1;
         s7_tod_in.second = 6'(mr_full - HOUR_REM_W'(SECS_PER_MIN));
      end else begin
         s7_tod_in.minute = min_est;
         s7_tod_in.second = 6'(mr_full);
      end
      s7_tod_in.hour    = s6_hour_ff;
      s7_tod_in.weekday = s6_wd_ff;
      s7_era_in = s6_era_ff;
      s7_doe_in = s6_doe_ff;
      s7_c_in   = s6_c_ff;
   end

   // year of era
   always_comb begin
      s8_era_in = s7_era_ff;
      s8_doe_in = s7_doe_ff;
      s8_tod_in = s7_tod_ff;
      // leap days folded out so that every year counts 365
      s8_t_in   = DOE_W'(s7_doe_ff - s7_a_ff + s7_b_ff - s7_c_ff);

      s9_era_in = s8_era_ff;
      s9_doe_in = s8_doe_ff;
      s9_t_in   = s8_t_ff;
      s9_tod_in = s8_tod_ff;
      s9_py_in  = s8_t_ff * RY[RY_W-1:0];

      yoe_est = YOE_W'(s9_py_ff >> DOE_W);
      yr_full = DOE_W'(s9_t_ff - yoe_est * DAYS_PER_YEAR);
      s10_yoe_in = (yr_full >= DOE_W'(DAYS_PER_YEAR)) ? yoe_est + YOE_W'(1) : yoe_est;
      s10_era_in = s9_era_ff;
      s10_doe_in = s9_doe_ff;
      s10_tod_in = s9_tod_ff;
   end

   // day of the march-based year, leap flag, month and final fields
   always_comb begin
      if (s10_yoe_ff >= YOE_W'(3 * YEARS_PER_CENT)) begin
         cent = 2'd3;
      end else if (s10_yoe_ff >= YOE_W'(2 * YEARS_PER_CENT)) begin
         cent = 2'd2;
      end else if (s10_yoe_ff >= YOE_W'(YEARS_PER_CENT)) begin
         cent = 2'd1;
      end else begin
         cent = 2'd0;
      end
      s11_doy_in  = 9'(s10_doe_ff - (s10_yoe_ff * DAYS_PER_YEAR + (s10_yoe_ff >> 2) - cent));
      // era start is a multiple of 400, so the year of era alone decides leap
      s11_leap_in = (s10_yoe_ff[1:0] == 2'b00)
                    && (s10_yoe_ff != YOE_W'(YEARS_PER_CENT))
                    && (s10_yoe_ff != YOE_W'(2 * YEARS_PER_CENT))
                    && (s10_yoe_ff != YOE_W'(3 * YEARS_PER_CENT));
      s11_year_in = Y_W'(s10_era_ff * YEARS_PER_ERA + s10_yoe_ff);
      s11_tod_in  = s10_tod_ff;

      for (int i = 1; i < MONTHS; i++) begin
         month_ge[i-1] = (s11_doy_ff >= month_start(4'(i)));
      end
      s12_mp_in   = 4'($countones(month_ge));
      s12_doy_in  = s11_doy_ff;
      s12_leap_in = s11_leap_ff;
      s12_year_in = s11_year_ff;
      s12_tod_in  = s11_tod_ff;

      // january and february belong to the next civil year
      jan_feb    = (s12_mp_ff >= 4'(FIRST_JAN_MP));
      year_full  = s12_year_ff + Y_W'(jan_feb);
      s13_year_in = 10'(year_full - Y_W'(YEAR_OFFSET));
      s13_dom_in  = 5'(s12_doy_ff - month_start(s12_mp_ff) + 9'd1);
      if (jan_feb) begin
         s13_month_in = s12_mp_ff - 4'(FIRST_JAN_MP);
         s13_doy_in   = s12_doy_ff - 9'(JAN_FIRST_DAY);
      end else begin
         s13_month_in = s12_mp_ff + 4'(MARCH_INDEX);
         s13_doy_in   = s12_doy_ff + 9'(JAN_FEB_DAYS) + 9'(s12_leap_ff);
      end
      s13_tod_in = s12_tod_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_nh_ff   <= s0_nh_in;
         s0_nl_ff   <= s0_nl_in;
         s0_lo_ff   <= s0_lo_in;
         s0_prod_ff <= s0_prod_in;
      end
      if (adv[1]) begin
         s1_qh_ff <= s1_qh_in;
         s1_rh_ff <= s1_rh_in;
         s1_nl_ff <= s1_nl_in;
         s1_lo_ff <= s1_lo_in;
      end
      if (adv[2]) begin
         s2_qh_ff   <= s2_qh_in;
         s2_lo_ff   <= s2_lo_in;
         s2_m_ff    <= s2_m_in;
         s2_prod_ff <= s2_prod_in;
      end
      if (adv[3]) begin
         s3_days_ff <= s3_days_in;
         s3_rem_ff  <= s3_rem_in;
      end
      if (adv[4]) begin
         s4_z_ff   <= s4_z_in;
         s4_pe_ff  <= s4_pe_in;
         s4_w_ff   <= s4_w_in;
         s4_p7_ff  <= s4_p7_in;
         s4_rem_ff <= s4_rem_in;
         s4_ph_ff  <= s4_ph_in;
      end
      if (adv[5]) begin
         s5_era_ff  <= s5_era_in;
         s5_doe_ff  <= s5_doe_in;
         s5_wd_ff   <= s5_wd_in;
         s5_hour_ff <= s5_hour_in;
         s5_r2_ff   <= s5_r2_in;
      end
      if (adv[6]) begin
         s6_era_ff  <= s6_era_in;
         s6_doe_ff  <= s6_doe_in;
         s6_c_ff    <= s6_c_in;
         s6_wd_ff   <= s6_wd_in;
         s6_hour_ff <= s6_hour_in;
         s6_r2_ff   <= s6_r2_in;
         s6_p4y_ff  <= s6_p4y_in;
         s6_pc_ff   <= s6_pc_in;
         s6_pm_ff   <= s6_pm_in;
      end
      if (adv[7]) begin
         s7_era_ff <= s7_era_in;
         s7_doe_ff <= s7_doe_in;
         s7_c_ff   <= s7_c_in;
         s7_a_ff   <= s7_a_in;
         s7_b_ff   <= s7_b_in;
         s7_tod_ff <= s7_tod_in;
      end
      if (adv[8]) begin
         s8_era_ff <= s8_era_in;
         s8_doe_ff <= s8_doe_in;
         s8_t_ff   <= s8_t_in;
         s8_tod_ff <= s8_tod_in;
      end
      if (adv[9]) begin
         s9_era_ff <= s9_era_in;
         s9_doe_ff <= s9_doe_in;
         s9_t_ff   <= s9_t_in;
         s9_py_ff  <= s9_py_in;
         s9_tod_ff <= s9_tod_in;
      end
      if (adv[10]) begin
         s10_era_ff <= s10_era_in;
         s10_doe_ff <= s10_doe_in;
         s10_yoe_ff <= s10_yoe_in;
         s10_tod_ff <= s10_tod_in;
      end
      if (adv[11]) begin
         s11_doy_ff  <= s11_doy_in;
         s11_leap_ff <= s11_leap_in;
         s11_year_ff <= s11_year_in;
         s11_tod_ff  <= s11_tod_in;
      end
      if (adv[12]) begin
         s12_doy_ff  <= s12_doy_in;
         s12_leap_ff <= s12_leap_in;
         s12_year_ff <= s12_year_in;
         s12_mp_ff   <= s12_mp_in;
         s12_tod_ff  <= s12_tod_in;
      end
      if (adv[13]) begin
         s13_tod_ff   <= s13_tod_in;
         s13_year_ff  <= s13_year_in;
         s13_doy_ff   <= s13_doy_in;
         s13_month_ff <= s13_month_in;
         s13_dom_ff   <= s13_dom_in;
      end
   end

   assign rsp_second           = s13_tod_ff.second;
   assign rsp_minute           = s13_tod_ff.minute;
   assign rsp_hour             = s13_tod_ff.hour;
   assign rsp_weekday          = s13_tod_ff.weekday;
   assign rsp_years_since_1900 = s13_year_ff;
   assign rsp_day_of_year      = s13_doy_ff;
   assign rsp_month_index      = s13_month_ff;
   assign rsp_day_of_month     = s13_dom_ff;

`ifndef SYNTHESIS
   // an accepted transfer always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted transfer not captured in stage 0");

   // day split correction leaves a proper time of day
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (s3_rem_ff < TOD_W'(SECS_PER_DAY)))
      else $error("seconds of day out of range");

   // year of era correction stays inside one era
   a_yoe_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[10] |-> (s10_yoe_ff < YOE_W'(YEARS_PER_ERA)))
      else $error("year of era out of range");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_index <= 4'd11) && (rsp_day_of_month != 5'd0)
                    && (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59)
                    && (rsp_second <= 6'd59) && (rsp_weekday <= 3'd6)
                    && (rsp_day_of_year <= 9'd365))
      else $error("result field out of range");
`endif

endmodule
